@@ design/pi_ocs_pkg.sv @@
// ----------------------------------------------------------------------------
// pi_ocs_pkg
// Shared codes and types of the PI drive regulator: event codes, run states,
// register indexes and the control state bundle.
// ----------------------------------------------------------------------------
package pi_ocs_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int TICK_WIDTH      = 32;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_SEL_OPEN = 2'd1,
        MODE_CLOSED   = 2'd2,
        MODE_STOP     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RUN_IDLE   = 2'd0,
        RUN_OPEN   = 2'd1,
        RUN_CLOSED = 2'd2,
        RUN_SAFE   = 2'd3
    } run_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PROP_GAIN        = 3'd0,
        REG_INTEGRAL_GAIN    = 3'd1,
        REG_DRIVE_MIN        = 3'd2,
        REG_DRIVE_MAX        = 3'd3,
        REG_INTEGRATOR_LIMIT = 3'd4,
        REG_TARGET           = 3'd5
    } reg_index_t;

    // Mode selection and run phase travel together between modules.
    typedef struct packed {
        logic closed;
        run_t run;
    } ctrl_t;

endpackage

@@ design/pi_ocs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pi_ocs_cfg_regs
// Configuration register file: gains, drive limits, integrator clamp and
// setpoint, written through a plain write port.
// ----------------------------------------------------------------------------
module pi_ocs_cfg_regs #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_write_en,
    input  logic [pi_ocs_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [DATA_WIDTH-1:0]                      cfg_data,
    output logic signed [DATA_WIDTH-1:0]               prop_gain,
    output logic signed [DATA_WIDTH-1:0]               integral_gain,
    output logic signed [DATA_WIDTH-1:0]               drive_min,
    output logic signed [DATA_WIDTH-1:0]               drive_max,
    output logic [DATA_WIDTH-2:0]                      integrator_limit,
    output logic signed [DATA_WIDTH-1:0]               target
);
    import pi_ocs_pkg::*;

    // 1.0 and 0.05 in the chosen fixed point format
    localparam logic [63:0] ONE_WIDE  = 64'(1) << FRAC_BITS;
    localparam logic [63:0] GAIN_WIDE = (ONE_WIDE + 64'd10) / 64'd20;
    localparam logic signed [DATA_WIDTH-1:0] ONE_Q  = ONE_WIDE[DATA_WIDTH-1:0];
    localparam logic signed [DATA_WIDTH-1:0] GAIN_Q = GAIN_WIDE[DATA_WIDTH-1:0];

    logic signed [DATA_WIDTH-1:0] prop_gain_reg;
    logic signed [DATA_WIDTH-1:0] integral_gain_reg;
    logic signed [DATA_WIDTH-1:0] drive_min_reg;
    logic signed [DATA_WIDTH-1:0] drive_max_reg;
    logic [DATA_WIDTH-2:0]        integrator_limit_reg;
    logic signed [DATA_WIDTH-1:0] target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg        <= ONE_Q;
            integral_gain_reg    <= GAIN_Q;
            drive_min_reg        <= -ONE_Q;
            drive_max_reg        <= ONE_Q;
            integrator_limit_reg <= ONE_Q[DATA_WIDTH-2:0];
            target_reg           <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:        prop_gain_reg        <= cfg_data;
                REG_INTEGRAL_GAIN:    integral_gain_reg    <= cfg_data;
                REG_DRIVE_MIN:        drive_min_reg        <= cfg_data;
                REG_DRIVE_MAX:        drive_max_reg        <= cfg_data;
                REG_INTEGRATOR_LIMIT: integrator_limit_reg <= cfg_data[DATA_WIDTH-2:0];
                REG_TARGET:           target_reg           <= cfg_data;
                default:              ; // drop writes beyond the register list
            endcase
        end
    end

    assign prop_gain        = prop_gain_reg;
    assign integral_gain    = integral_gain_reg;
    assign drive_min        = drive_min_reg;
    assign drive_max        = drive_max_reg;
    assign integrator_limit = integrator_limit_reg;
    assign target           = target_reg;

endmodule

@@ design/pi_ocs_datapath.sv @@
// ----------------------------------------------------------------------------
// pi_ocs_datapath
// Next-state logic for one event: open loop clamp, PI terms with integrator
// clamp, drive clamp, saturating counters and overshoot peak.
// ----------------------------------------------------------------------------
module pi_ocs_datapath #(
    parameter int DATA_WIDTH  = 16,
    parameter int FRAC_BITS   = 12,
    parameter int COUNT_WIDTH = 16
) (
    input  pi_ocs_pkg::mode_t                     mode,
    input  logic signed [DATA_WIDTH-1:0]          measured,
    input  logic signed [DATA_WIDTH-1:0]          open_command,
    input  logic signed [DATA_WIDTH-1:0]          prop_gain,
    input  logic signed [DATA_WIDTH-1:0]          integral_gain,
    input  logic signed [DATA_WIDTH-1:0]          drive_min,
    input  logic signed [DATA_WIDTH-1:0]          drive_max,
    input  logic [DATA_WIDTH-2:0]                 integrator_limit,
    input  logic signed [DATA_WIDTH-1:0]          target,
    input  pi_ocs_pkg::ctrl_t                     ctrl,
    input  logic signed [DATA_WIDTH-1:0]          integrator,
    input  logic signed [DATA_WIDTH-1:0]          drive,
    input  logic [pi_ocs_pkg::TICK_WIDTH-1:0]     tick_count,
    input  logic [COUNT_WIDTH-1:0]                sat_count,
    input  logic [COUNT_WIDTH-1:0]                mode_count,
    input  logic [DATA_WIDTH-2:0]                 peak,
    output pi_ocs_pkg::ctrl_t                     ctrl_next,
    output logic signed [DATA_WIDTH-1:0]          integrator_next,
    output logic signed [DATA_WIDTH-1:0]          drive_next,
    output logic [pi_ocs_pkg::TICK_WIDTH-1:0]     tick_count_next,
    output logic [COUNT_WIDTH-1:0]                sat_count_next,
    output logic [COUNT_WIDTH-1:0]                mode_count_next,
    output logic [DATA_WIDTH-2:0]                 peak_next
);
    import pi_ocs_pkg::*;

    // products of a gain and an error one bit wider than the data
    localparam int PW = 2 * DATA_WIDTH + 1;

    logic signed [DATA_WIDTH:0] err;
    logic signed [DATA_WIDTH:0] over;
    logic signed [PW-1:0]       p_term;
    logic signed [PW-1:0]       i_term;
    logic signed [PW-1:0]       lim_w;
    logic signed [PW-1:0]       integ_sum;
    logic signed [PW-1:0]       integ_clamped;
    logic signed [PW-1:0]       raw;
    logic signed [PW-1:0]       dmin_w;
    logic signed [PW-1:0]       dmax_w;
    logic signed [PW-1:0]       raw_clamped;
    logic signed [DATA_WIDTH-1:0] cmd_clamped;
    logic                       want_closed;
    logic [COUNT_WIDTH-1:0]     sat_inc;
    logic [COUNT_WIDTH-1:0]     mode_inc;
    logic [TICK_WIDTH-1:0]      tick_inc;

    assign err  = (DATA_WIDTH+1)'(target) - (DATA_WIDTH+1)'(measured);
    assign over = (DATA_WIDTH+1)'(measured) - (DATA_WIDTH+1)'(target);

    // arithmetic shift rounds toward minus infinity
    assign p_term = (PW'(prop_gain) * PW'(err)) >>> FRAC_BITS;
    assign i_term = (PW'(integral_gain) * PW'(err)) >>> FRAC_BITS;

    assign lim_w     = PW'(signed'({1'b0, integrator_limit}));
    assign integ_sum = PW'(integrator) + i_term;

    always_comb
    begin
        if (integ_sum < -lim_w)
            integ_clamped = -lim_w;
        else if (integ_sum > lim_w)
            integ_clamped = lim_w;
        else
            integ_clamped = integ_sum;
    end

    assign raw    = p_term + integ_clamped;
    assign dmin_w = PW'(drive_min);
    assign dmax_w = PW'(drive_max);

    // with inverted limits, raw below drive_min gives drive_min, else drive_max
    always_comb
    begin
        if (raw < dmin_w)
            raw_clamped = dmin_w;
        else if (raw > dmax_w)
            raw_clamped = dmax_w;
        else
            raw_clamped = raw;
    end

    always_comb
    begin
        if (open_command < drive_min)
            cmd_clamped = drive_min;
        else if (open_command > drive_max)
            cmd_clamped = drive_max;
        else
            cmd_clamped = open_command;
    end

    assign sat_inc  = (sat_count == '1) ? sat_count : sat_count + 1'b1;
    assign mode_inc = (mode_count == '1) ? mode_count : mode_count + 1'b1;
    assign tick_inc = (tick_count == '1) ? tick_count : tick_count + 1'b1;
    assign want_closed = (mode == MODE_CLOSED);

    always_comb
    begin
        ctrl_next       = ctrl;
        integrator_next = integrator;
        drive_next      = drive;
        tick_count_next = tick_count;
        sat_count_next  = sat_count;
        mode_count_next = mode_count;
        peak_next       = peak;
        unique case (mode)
            MODE_TICK:
            begin
                tick_count_next = tick_inc;
                if (ctrl.run == RUN_SAFE)
                begin
                    drive_next = '0;
                end
                else if (!ctrl.closed)
                begin
                    drive_next = cmd_clamped;
                    if (cmd_clamped == drive_min || cmd_clamped == drive_max)
                        sat_count_next = sat_inc;
                end
                else
                begin
                    integrator_next = integ_clamped[DATA_WIDTH-1:0];
                    drive_next      = raw_clamped[DATA_WIDTH-1:0];
                    if (raw_clamped != raw)
                        sat_count_next = sat_inc;
                    if (target > 0 && over > (DATA_WIDTH+1)'(signed'({2'b00, peak})))
                        peak_next = over[DATA_WIDTH-2:0];
                end
            end
            MODE_STOP:
            begin
                ctrl_next.run = RUN_SAFE;
                drive_next    = '0;
            end
            MODE_SEL_OPEN, MODE_CLOSED:
            begin
                if (ctrl.closed != want_closed)
                begin
                    ctrl_next.closed = want_closed;
                    mode_count_next  = mode_inc;
                end
                // only reset leaves the safe state
                if (ctrl.run != RUN_SAFE)
                    ctrl_next.run = want_closed ? RUN_CLOSED : RUN_OPEN;
            end
            default:
            begin
                ctrl_next = ctrl;
            end
        endcase
    end

endmodule

@@ design/pi_controller_open_closed_safe_top.sv @@
// ----------------------------------------------------------------------------
// pi_controller_open_closed_safe_top
// PI drive regulator with open and closed loop modes, anti-windup clamp,
// saturating event counters, overshoot tracking and a latched safe stop.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   mode, measured, open_command
//   out      source     out_valid / out_stall drive, run_state, loop_closed,
//                                             sat_events, mode_change_events,
//                                             peak_overshoot, tick_total
//   cfg      sink       cfg_write_en          cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; an accepted input
// is captured in the input register, feeds the combinational PI datapath, and
// its outputs land in the state/result register when the transaction advances.
// The regulator state doubles as the result register, so a result holds
// while out_stall is high; the input register then fills and in_stall rises.
// Reset restores register defaults and clears the regulator state and valid flags at once.
// ----------------------------------------------------------------------------
module pi_controller_open_closed_safe_top #(
    parameter int DATA_WIDTH  = 16,
    parameter int FRAC_BITS   = 12,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write_en,
    input  logic [pi_ocs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [DATA_WIDTH-1:0]                  cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             mode,
    input  logic signed [DATA_WIDTH-1:0]           measured,
    input  logic signed [DATA_WIDTH-1:0]           open_command,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [DATA_WIDTH-1:0]           drive,
    output logic [1:0]                             run_state,
    output logic                                   loop_closed,
    output logic [COUNT_WIDTH-1:0]                 sat_events,
    output logic [COUNT_WIDTH-1:0]                 mode_change_events,
    output logic [DATA_WIDTH-2:0]                  peak_overshoot,
    output logic [pi_ocs_pkg::TICK_WIDTH-1:0]      tick_total
);
    import pi_ocs_pkg::*;

    logic signed [DATA_WIDTH-1:0] prop_gain;
    logic signed [DATA_WIDTH-1:0] integral_gain;
    logic signed [DATA_WIDTH-1:0] drive_min;
    logic signed [DATA_WIDTH-1:0] drive_max;
    logic [DATA_WIDTH-2:0]        integrator_limit;
    logic signed [DATA_WIDTH-1:0] target;

    logic                         in_valid_reg;
    mode_t                        mode_reg;
    logic signed [DATA_WIDTH-1:0] measured_reg;
    logic signed [DATA_WIDTH-1:0] open_command_reg;
    logic                         out_valid_reg;
    logic                         advance;

    ctrl_t                        ctrl_reg;
    ctrl_t                        ctrl_next;
    logic signed [DATA_WIDTH-1:0] integrator_reg;
    logic signed [DATA_WIDTH-1:0] integrator_next;
    logic signed [DATA_WIDTH-1:0] drive_reg;
    logic signed [DATA_WIDTH-1:0] drive_next;
    logic [TICK_WIDTH-1:0]        tick_reg;
    logic [TICK_WIDTH-1:0]        tick_next;
    logic [COUNT_WIDTH-1:0]       sat_reg;
    logic [COUNT_WIDTH-1:0]       sat_next;
    logic [COUNT_WIDTH-1:0]       mode_cnt_reg;
    logic [COUNT_WIDTH-1:0]       mode_cnt_next;
    logic [DATA_WIDTH-2:0]        peak_reg;
    logic [DATA_WIDTH-2:0]        peak_next;

    pi_ocs_cfg_regs #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .prop_gain        (prop_gain),
        .integral_gain    (integral_gain),
        .drive_min        (drive_min),
        .drive_max        (drive_max),
        .integrator_limit (integrator_limit),
        .target           (target)
    );

    pi_ocs_datapath #(
        .DATA_WIDTH  (DATA_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .mode             (mode_reg),
        .measured         (measured_reg),
        .open_command     (open_command_reg),
        .prop_gain        (prop_gain),
        .integral_gain    (integral_gain),
        .drive_min        (drive_min),
        .drive_max        (drive_max),
        .integrator_limit (integrator_limit),
        .target           (target),
        .ctrl             (ctrl_reg),
        .integrator       (integrator_reg),
        .drive            (drive_reg),
        .tick_count       (tick_reg),
        .sat_count        (sat_reg),
        .mode_count       (mode_cnt_reg),
        .peak             (peak_reg),
        .ctrl_next        (ctrl_next),
        .integrator_next  (integrator_next),
        .drive_next       (drive_next),
        .tick_count_next  (tick_next),
        .sat_count_next   (sat_next),
        .mode_count_next  (mode_cnt_next),
        .peak_next        (peak_next)
    );

    // advance the held transaction whenever the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg         <= mode_t'(mode);
            measured_reg     <= measured;
            open_command_reg <= open_command;
        end
    end

    // regulator state, also the visible result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg       <= '{closed: 1'b0, run: RUN_IDLE};
            integrator_reg <= '0;
            drive_reg      <= '0;
            tick_reg       <= '0;
            sat_reg        <= '0;
            mode_cnt_reg   <= '0;
            peak_reg       <= '0;
        end
        else if (advance)
        begin
            ctrl_reg       <= ctrl_next;
            integrator_reg <= integrator_next;
            drive_reg      <= drive_next;
            tick_reg       <= tick_next;
            sat_reg        <= sat_next;
            mode_cnt_reg   <= mode_cnt_next;
            peak_reg       <= peak_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign drive              = drive_reg;
    assign run_state          = ctrl_reg.run;
    assign loop_closed        = ctrl_reg.closed;
    assign sat_events         = sat_reg;
    assign mode_change_events = mode_cnt_reg;
    assign peak_overshoot     = peak_reg;
    assign tick_total         = tick_reg;

    a_stop_safe: assert property (@(posedge clk) disable iff (!rst_n)
        advance && mode_reg == MODE_STOP |=> run_state == RUN_SAFE && drive == '0)
        else $error("stop did not reach safe state with zero drive");

    a_safe_latched: assert property (@(posedge clk) disable iff (!rst_n)
        run_state == RUN_SAFE |=> run_state == RUN_SAFE)
        else $error("safe state left without reset");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(drive) && $stable(tick_total)
            && $stable(sat_events))
        else $error("stalled result changed");

    a_tick_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> tick_total >= $past(tick_total))
        else $error("tick count went backward");

endmodule
